### src/multi_queue_task_fifo_assert.svh
// Assertion macros for the multi-queue task FIFO.
// Expects signals named clk and rst_n in the scope that uses them.
`ifndef MULTI_QUEUE_TASK_FIFO_ASSERT_SVH
`define MULTI_QUEUE_TASK_FIFO_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MQTF_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MQTF_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/mqtf_pkg.sv
// Shared constants, codes and types of the multi-queue task FIFO.
// No dependencies; every other file but the assertion header imports this package.
package mqtf_pkg;

    localparam int USER_DEPTH   = 16;
    localparam int LAYER_DEPTH  = 16;
    localparam int LAYER_QUEUES = 4;
    localparam int NUM_QUEUES   = LAYER_QUEUES + 1;

    localparam int PTR_W   = 8;
    localparam int WORD_W  = 32;
    localparam int SLOT_W  = 2 * WORD_W;
    localparam int CMD_W   = 2;
    localparam int QSEL_W  = 3;
    localparam int STAT_W  = 2;
    localparam int DIFF_W  = PTR_W + 1;
    localparam int QIDX_W  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int UA_W    = $clog2(USER_DEPTH);
    localparam int LD_W    = $clog2(LAYER_DEPTH);
    localparam int LMEM_DEPTH = LAYER_QUEUES * LAYER_DEPTH;
    localparam int LA_W    = (LMEM_DEPTH > 1) ? $clog2(LMEM_DEPTH) : 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_QUERY = 2'd2
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } status_t;

    // Strobes from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
        logic finish;
    } mqtf_ctl_t;

endpackage

### src/mqtf_stream_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on mqtf_pkg for field widths.
interface mqtf_req_if
    import mqtf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [QSEL_W-1:0] queue_index;
    logic [WORD_W-1:0] callback_in;
    logic [WORD_W-1:0] data_in;

    modport source (output valid, cmd, queue_index, callback_in, data_in, input ready);
    modport sink   (input valid, cmd, queue_index, callback_in, data_in, output ready);
endinterface

interface mqtf_rsp_if
    import mqtf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [WORD_W-1:0] callback_out;
    logic [WORD_W-1:0] data_out;
    logic [PTR_W-1:0]  user_count;
    logic              all_empty;

    modport source (output valid, status, callback_out, data_out, user_count, all_empty,
                    input ready);
    modport sink   (input valid, status, callback_out, data_out, user_count, all_empty,
                    output ready);
endinterface

### src/mqtf_ctrl.sv
// Sequencing controller: accepts a request, runs it, then hands the beat out.
// Depends on mqtf_pkg.
module mqtf_ctrl
    import mqtf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output mqtf_ctl_t ctl
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free   = !out_valid_reg || out_ready;
    assign in_ready    = (state_reg == S_IDLE);
    assign ctl.capture = in_ready && in_valid;
    assign ctl.exec    = (state_reg == S_EXEC);
    assign ctl.finish  = (state_reg == S_DONE) && slot_free;
    assign out_valid   = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (ctl.capture)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (ctl.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### src/mqtf_datapath.sv
// Queue datapath: pointer registers, slot memories and the response register.
// Depends on mqtf_pkg; driven by strobes from mqtf_ctrl.
module mqtf_datapath
    import mqtf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  mqtf_ctl_t         ctl,
    input  logic [CMD_W-1:0]  cmd,
    input  logic [QSEL_W-1:0] queue_index,
    input  logic [WORD_W-1:0] callback_in,
    input  logic [WORD_W-1:0] data_in,
    output logic [STAT_W-1:0] status,
    output logic [WORD_W-1:0] callback_out,
    output logic [WORD_W-1:0] data_out,
    output logic [PTR_W-1:0]  user_count,
    output logic              all_empty
);

    // Captured request.
    logic [CMD_W-1:0]  cmd_reg;
    logic [QSEL_W-1:0] q_reg;
    logic [SLOT_W-1:0] slot_reg;

    logic [PTR_W-1:0] wr_ptr_reg  [NUM_QUEUES];
    logic [PTR_W-1:0] wr_ptr_next [NUM_QUEUES];
    logic [PTR_W-1:0] rd_ptr_reg  [NUM_QUEUES];
    logic [PTR_W-1:0] rd_ptr_next [NUM_QUEUES];

    logic [SLOT_W-1:0] user_mem  [USER_DEPTH];
    logic [SLOT_W-1:0] layer_mem [LMEM_DEPTH];
    logic [SLOT_W-1:0] user_rd_reg;
    logic [SLOT_W-1:0] layer_rd_reg;

    logic [STAT_W-1:0] status_reg;
    logic              pop_ok_reg;
    logic              is_user_reg;

    logic [STAT_W-1:0] status_out_reg;
    logic [WORD_W-1:0] callback_out_reg;
    logic [WORD_W-1:0] data_out_reg;
    logic [PTR_W-1:0]  user_count_reg;
    logic              all_empty_reg;

    logic                     q_valid;
    logic                     is_user;
    logic [QIDX_W-1:0]        qi;
    logic [QIDX_W-1:0]        lq;
    logic [PTR_W-1:0]         wr_ptr;
    logic [PTR_W-1:0]         rd_ptr;
    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] depth;
    logic                     full;
    logic                     empty;
    logic                     push_ok;
    logic                     pop_ok;
    logic [STAT_W-1:0]        status_next;
    logic [UA_W-1:0]          user_wr_addr;
    logic [UA_W-1:0]          user_rd_addr;
    logic [LA_W-1:0]          layer_wr_addr;
    logic [LA_W-1:0]          layer_rd_addr;
    logic                     none_pending;
    logic [SLOT_W-1:0]        pop_slot;

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg  <= cmd;
            q_reg    <= queue_index;
            slot_reg <= {callback_in, data_in};
        end
    end

    assign q_valid = (int'(q_reg) < NUM_QUEUES);
    assign is_user = (q_reg == '0);
    assign qi      = q_valid ? QIDX_W'(q_reg) : '0;
    assign lq      = qi - QIDX_W'(1);
    assign wr_ptr  = wr_ptr_reg[qi];
    assign rd_ptr  = rd_ptr_reg[qi];

    // Full test on the plain signed difference; a wrapped write pointer gives a
    // negative difference and lets the push through.
    assign diff  = $signed({1'b0, wr_ptr}) - $signed({1'b0, rd_ptr});
    assign depth = is_user ? DIFF_W'(USER_DEPTH) : DIFF_W'(LAYER_DEPTH);
    assign full  = (diff >= depth);
    assign empty = (wr_ptr == rd_ptr);

    assign push_ok = ctl.exec && (cmd_reg == CMD_PUSH) && q_valid && !full;
    assign pop_ok  = ctl.exec && (cmd_reg == CMD_POP) && q_valid && !empty;

    always_comb
    begin
        priority if (cmd_reg == CMD_PUSH && !push_ok)
        begin
            status_next = ST_OVERFLOW;
        end
        else if (cmd_reg == CMD_POP && !pop_ok)
        begin
            status_next = ST_EMPTY;
        end
        else
        begin
            status_next = ST_OK;
        end
    end

    assign user_wr_addr  = wr_ptr[UA_W-1:0];
    assign user_rd_addr  = rd_ptr[UA_W-1:0];
    assign layer_wr_addr = LA_W'({lq, wr_ptr[LD_W-1:0]});
    assign layer_rd_addr = LA_W'({lq, rd_ptr[LD_W-1:0]});

    always_ff @(posedge clk)
    begin
        if (push_ok && is_user)
        begin
            user_mem[user_wr_addr] <= slot_reg;
        end
        if (pop_ok && is_user)
        begin
            user_rd_reg <= user_mem[user_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok && !is_user)
        begin
            layer_mem[layer_wr_addr] <= slot_reg;
        end
        if (pop_ok && !is_user)
        begin
            layer_rd_reg <= layer_mem[layer_rd_addr];
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_QUEUES; i++)
        begin
            wr_ptr_next[i] = wr_ptr_reg[i];
            rd_ptr_next[i] = rd_ptr_reg[i];
        end
        if (push_ok)
        begin
            wr_ptr_next[qi] = wr_ptr + PTR_W'(1);
        end
        if (pop_ok)
        begin
            rd_ptr_next[qi] = rd_ptr + PTR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                wr_ptr_reg[i] <= '0;
                rd_ptr_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                wr_ptr_reg[i] <= wr_ptr_next[i];
                rd_ptr_reg[i] <= rd_ptr_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.exec)
        begin
            status_reg  <= status_next;
            pop_ok_reg  <= pop_ok;
            is_user_reg <= is_user;
        end
    end

    always_comb
    begin
        none_pending = 1'b1;
        for (int i = 0; i < NUM_QUEUES; i++)
        begin
            if (wr_ptr_reg[i] != rd_ptr_reg[i])
            begin
                none_pending = 1'b0;
            end
        end
    end

    assign pop_slot = is_user_reg ? user_rd_reg : layer_rd_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.finish)
        begin
            status_out_reg   <= status_reg;
            callback_out_reg <= pop_ok_reg ? pop_slot[SLOT_W-1:WORD_W] : '0;
            data_out_reg     <= pop_ok_reg ? pop_slot[WORD_W-1:0] : '0;
            user_count_reg   <= wr_ptr_reg[0] - rd_ptr_reg[0];
            all_empty_reg    <= none_pending;
        end
    end

    assign status       = status_out_reg;
    assign callback_out = callback_out_reg;
    assign data_out     = data_out_reg;
    assign user_count   = user_count_reg;
    assign all_empty    = all_empty_reg;

endmodule

### src/multi_queue_task_fifo.sv
// Each request runs through capture, execute with the slot memory access, then load
// of the response register; no new request is taken before that load, and a stalled
// response holds the next request in its done step. Reset clears all queue pointers
// at once; the slot memories are not cleared and hold unknown data until written.
`include "multi_queue_task_fifo_assert.svh"

module multi_queue_task_fifo
    import mqtf_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    mqtf_req_if.sink   req,
    mqtf_rsp_if.source rsp
);

    mqtf_ctl_t ctl;

    mqtf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .ctl       (ctl)
    );

    mqtf_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .cmd          (req.cmd),
        .queue_index  (req.queue_index),
        .callback_in  (req.callback_in),
        .data_in      (req.data_in),
        .status       (rsp.status),
        .callback_out (rsp.callback_out),
        .data_out     (rsp.data_out),
        .user_count   (rsp.user_count),
        .all_empty    (rsp.all_empty)
    );

    // Only one request is in flight at a time.
    `MQTF_ASSERT_NXT(a_one_in_flight, req.valid && req.ready, !req.ready,
                     "second request taken while busy")

    // Only a successful pop carries payload words.
    `MQTF_ASSERT_IMP(a_zero_payload, rsp.valid && rsp.status != ST_OK,
                     rsp.callback_out == '0 && rsp.data_out == '0,
                     "payload on failed command")

    // All queues empty implies an empty user queue.
    `MQTF_ASSERT_IMP(a_empty_count, rsp.valid && rsp.all_empty, rsp.user_count == '0,
                     "user count nonzero while all empty")

    // The execute step never overlaps the response load or the capture.
    `MQTF_ASSERT_IMP(a_ctl_excl, ctl.exec, !ctl.finish && !ctl.capture,
                     "controller strobes overlap")

endmodule
